// ----- design/tps_pkg.sv -----
// Shared constants, types and widths of the tree parent selector.
`timescale 1ns / 1ps
package tps_pkg;

  localparam int TABLE_DEPTH = 16;
  localparam int ADDR_BITS   = 16;

  localparam int IN_ADDR_W  = 16;
  localparam int RANK_W     = 8;
  localparam int RSSI_W     = 16;
  localparam int OWN_RANK_W = 9;

  localparam int KEY_W = (ADDR_BITS < IN_ADDR_W) ? ADDR_BITS : IN_ADDR_W;
  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  localparam logic [OWN_RANK_W-1:0] RANK_AT_RESET = OWN_RANK_W'(100);

  typedef struct packed {
    logic [KEY_W-1:0]  addr;
    logic [RANK_W-1:0] rank;
    logic [RSSI_W-1:0] rssi;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic hit;
    logic better;
  } cmp_res_t;

endpackage

// ----- design/tps_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
module tps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- design/tps_cmp.sv -----
// Shared compare unit: address match and parent preference for one table entry.
`timescale 1ns / 1ps
module tps_cmp (
  input  tps_pkg::entry_t                 entry,
  input  logic [tps_pkg::KEY_W-1:0]       key,
  input  logic                            best_valid,
  input  logic [tps_pkg::RANK_W-1:0]      best_rank,
  input  logic [tps_pkg::RSSI_W-1:0]      best_rssi,
  output tps_pkg::cmp_res_t               res
);
  import tps_pkg::*;

  always_comb begin
    res.hit    = (entry.addr == key);
    res.better = !best_valid ||
                 (entry.rank < best_rank) ||
                 ((entry.rank == best_rank) && (entry.rssi > best_rssi));
  end

endmodule

// ----- design/tree_parent_selector_unit.sv -----
// Top level: sequencer over the neighbour table, one compare unit shared by both passes.
// A transfer runs through lookup, update, scan and finish; a reply dropped at a full table skips
// the scan. Busy falls with the strobe and the next transfer may be accepted in that cycle, so a
// new transfer is taken only once the previous one has produced its result.
// Reset is synchronous; the table needs no clearing pass.
`timescale 1ns / 1ps
module tree_parent_selector_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic [tps_pkg::IN_ADDR_W-1:0]       in_neighbor_addr,
  input  logic [tps_pkg::RANK_W-1:0]          in_neighbor_rank,
  input  logic [tps_pkg::RSSI_W-1:0]          in_link_rssi,
  output logic                                out_valid,
  output logic                                out_accepted,
  output logic                                out_joined,
  output logic                                out_has_parent,
  output logic [tps_pkg::IN_ADDR_W-1:0]       out_parent_addr,
  output logic [tps_pkg::OWN_RANK_W-1:0]      out_own_rank
);
  import tps_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_UPDATE,
    ST_SCAN,
    ST_FINISH
  } state_t;

  state_t state_r, state_nxt;

  logic [CNT_W-1:0]      idx_r, idx_nxt;
  logic                  cmp_v_r, cmp_v_nxt;
  logic [IDX_W-1:0]      cmp_idx_r, cmp_idx_nxt;
  logic [KEY_W-1:0]      req_addr_r, req_addr_nxt;
  logic [RANK_W-1:0]     req_rank_r, req_rank_nxt;
  logic [RSSI_W-1:0]     req_rssi_r, req_rssi_nxt;
  logic                  hit_r, hit_nxt;
  logic [IDX_W-1:0]      hit_slot_r, hit_slot_nxt;
  logic [RANK_W-1:0]     hit_rank_r, hit_rank_nxt;
  logic                  acc_r, acc_nxt;
  logic [CNT_W-1:0]      count_r, count_nxt;
  logic                  parent_valid_r, parent_valid_nxt;
  logic [IDX_W-1:0]      parent_slot_r, parent_slot_nxt;
  logic [RANK_W-1:0]     parent_rank_r, parent_rank_nxt;
  logic [RSSI_W-1:0]     parent_rssi_r, parent_rssi_nxt;
  logic [KEY_W-1:0]      parent_addr_r, parent_addr_nxt;
  logic [OWN_RANK_W-1:0] node_rank_r, node_rank_nxt;
  logic                  joined_r, joined_nxt;

  logic                  out_valid_r, out_valid_nxt;
  logic                  out_accepted_r, out_accepted_nxt;
  logic                  out_joined_r, out_joined_nxt;
  logic                  out_has_parent_r, out_has_parent_nxt;
  logic [IN_ADDR_W-1:0]  out_parent_addr_r, out_parent_addr_nxt;
  logic [OWN_RANK_W-1:0] out_own_rank_r, out_own_rank_nxt;

  logic                  ram_we;
  logic [IDX_W-1:0]      ram_waddr;
  entry_t                ram_wdata;
  entry_t                ram_rdata;
  logic [ENTRY_W-1:0]    ram_rdata_bits;
  cmp_res_t              cmp_res;
  logic                  issue;

  assign ram_rdata = entry_t'(ram_rdata_bits);
  assign issue     = (idx_r != count_r);

  tps_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (idx_r[IDX_W-1:0]),
    .rdata (ram_rdata_bits)
  );

  tps_cmp u_cmp (
    .entry      (ram_rdata),
    .key        (req_addr_r),
    .best_valid (parent_valid_r),
    .best_rank  (parent_rank_r),
    .best_rssi  (parent_rssi_r),
    .res        (cmp_res)
  );

  always_comb begin
    state_nxt           = state_r;
    idx_nxt             = idx_r;
    cmp_v_nxt           = cmp_v_r;
    cmp_idx_nxt         = cmp_idx_r;
    req_addr_nxt        = req_addr_r;
    req_rank_nxt        = req_rank_r;
    req_rssi_nxt        = req_rssi_r;
    hit_nxt             = hit_r;
    hit_slot_nxt        = hit_slot_r;
    hit_rank_nxt        = hit_rank_r;
    acc_nxt             = acc_r;
    count_nxt           = count_r;
    parent_valid_nxt    = parent_valid_r;
    parent_slot_nxt     = parent_slot_r;
    parent_rank_nxt     = parent_rank_r;
    parent_rssi_nxt     = parent_rssi_r;
    parent_addr_nxt     = parent_addr_r;
    node_rank_nxt       = node_rank_r;
    joined_nxt          = joined_r;
    out_valid_nxt       = 1'b0;
    out_accepted_nxt    = out_accepted_r;
    out_joined_nxt      = out_joined_r;
    out_has_parent_nxt  = out_has_parent_r;
    out_parent_addr_nxt = out_parent_addr_r;
    out_own_rank_nxt    = out_own_rank_r;
    ram_we              = 1'b0;
    ram_waddr           = hit_slot_r;
    ram_wdata           = '{addr: req_addr_r, rank: hit_rank_r, rssi: req_rssi_r};

    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          req_addr_nxt = in_neighbor_addr[KEY_W-1:0];
          req_rank_nxt = in_neighbor_rank;
          req_rssi_nxt = in_link_rssi;
          idx_nxt      = '0;
          cmp_v_nxt    = 1'b0;
          hit_nxt      = 1'b0;
          state_nxt    = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        cmp_v_nxt   = issue;
        cmp_idx_nxt = idx_r[IDX_W-1:0];
        idx_nxt     = idx_r + CNT_W'(issue);
        if (cmp_v_r && cmp_res.hit) begin
          hit_nxt      = 1'b1;
          hit_slot_nxt = cmp_idx_r;
          hit_rank_nxt = ram_rdata.rank;
          cmp_v_nxt    = 1'b0;
          state_nxt    = ST_UPDATE;
        end else if (!issue && !cmp_v_r) begin
          state_nxt = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        idx_nxt   = '0;
        cmp_v_nxt = 1'b0;
        if (hit_r) begin
          ram_we     = 1'b1;
          acc_nxt    = 1'b1;
          joined_nxt = 1'b1;
          if (parent_valid_r && (parent_slot_r == hit_slot_r)) begin
            parent_rssi_nxt = req_rssi_r;
          end
          state_nxt = ST_SCAN;
        end else if (count_r != CNT_W'(TABLE_DEPTH)) begin
          ram_we     = 1'b1;
          ram_waddr  = count_r[IDX_W-1:0];
          ram_wdata  = '{addr: req_addr_r, rank: req_rank_r, rssi: req_rssi_r};
          count_nxt  = count_r + CNT_W'(1);
          acc_nxt    = 1'b1;
          joined_nxt = 1'b1;
          state_nxt  = ST_SCAN;
        end else begin
          acc_nxt   = 1'b0;
          state_nxt = ST_FINISH;
        end
      end
      ST_SCAN: begin
        cmp_v_nxt   = issue;
        cmp_idx_nxt = idx_r[IDX_W-1:0];
        idx_nxt     = idx_r + CNT_W'(issue);
        if (cmp_v_r && cmp_res.better) begin
          parent_valid_nxt = 1'b1;
          parent_slot_nxt  = cmp_idx_r;
          parent_rank_nxt  = ram_rdata.rank;
          parent_rssi_nxt  = ram_rdata.rssi;
          parent_addr_nxt  = ram_rdata.addr;
        end
        if (!issue && !cmp_v_r) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (parent_valid_r) begin
          node_rank_nxt = OWN_RANK_W'(parent_rank_r) + OWN_RANK_W'(1);
        end
        out_valid_nxt       = 1'b1;
        out_accepted_nxt    = acc_r;
        out_joined_nxt      = joined_r;
        out_has_parent_nxt  = parent_valid_r;
        out_parent_addr_nxt = parent_valid_r ? IN_ADDR_W'(parent_addr_r) : '0;
        out_own_rank_nxt    = node_rank_nxt;
        state_nxt           = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      cmp_v_r        <= 1'b0;
      count_r        <= '0;
      parent_valid_r <= 1'b0;
      parent_slot_r  <= '0;
      node_rank_r    <= RANK_AT_RESET;
      joined_r       <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      cmp_v_r        <= cmp_v_nxt;
      count_r        <= count_nxt;
      parent_valid_r <= parent_valid_nxt;
      parent_slot_r  <= parent_slot_nxt;
      node_rank_r    <= node_rank_nxt;
      joined_r       <= joined_nxt;
      out_valid_r    <= out_valid_nxt;
    end
    idx_r             <= idx_nxt;
    cmp_idx_r         <= cmp_idx_nxt;
    req_addr_r        <= req_addr_nxt;
    req_rank_r        <= req_rank_nxt;
    req_rssi_r        <= req_rssi_nxt;
    hit_r             <= hit_nxt;
    hit_slot_r        <= hit_slot_nxt;
    hit_rank_r        <= hit_rank_nxt;
    acc_r             <= acc_nxt;
    parent_rank_r     <= parent_rank_nxt;
    parent_rssi_r     <= parent_rssi_nxt;
    parent_addr_r     <= parent_addr_nxt;
    out_accepted_r    <= out_accepted_nxt;
    out_joined_r      <= out_joined_nxt;
    out_has_parent_r  <= out_has_parent_nxt;
    out_parent_addr_r <= out_parent_addr_nxt;
    out_own_rank_r    <= out_own_rank_nxt;
  end

  assign busy            = (state_r != ST_IDLE);
  assign out_valid       = out_valid_r;
  assign out_accepted    = out_accepted_r;
  assign out_joined      = out_joined_r;
  assign out_has_parent  = out_has_parent_r;
  assign out_parent_addr = out_parent_addr_r;
  assign out_own_rank    = out_own_rank_r;

endmodule

// ----- tb/tps_reply_checker.sv -----
// Checker for the tree parent selector: predicts each result from accepted transfers and compares.
`timescale 1ns / 1ps
module tps_reply_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic                           busy,
  input  logic [tps_pkg::IN_ADDR_W-1:0]  in_neighbor_addr,
  input  logic [tps_pkg::RANK_W-1:0]     in_neighbor_rank,
  input  logic [tps_pkg::RSSI_W-1:0]     in_link_rssi,
  input  logic                           out_valid,
  input  logic                           out_accepted,
  input  logic                           out_joined,
  input  logic                           out_has_parent,
  input  logic [tps_pkg::IN_ADDR_W-1:0]  out_parent_addr,
  input  logic [tps_pkg::OWN_RANK_W-1:0] out_own_rank,
  output int                             mismatches,
  output int                             pending
);
  import tps_pkg::*;

  typedef struct packed {
    logic                  accepted;
    logic                  joined;
    logic                  has_parent;
    logic [IN_ADDR_W-1:0]  parent_addr;
    logic [OWN_RANK_W-1:0] own_rank;
  } reply_result_t;

  logic [KEY_W-1:0]      nbr_addr [TABLE_DEPTH];
  logic [RANK_W-1:0]     nbr_rank [TABLE_DEPTH];
  logic [RSSI_W-1:0]     nbr_rssi [TABLE_DEPTH];
  int                    nbr_count = 0;
  int                    parent_idx = 0;
  logic                  parent_ok = 1'b0;
  logic [OWN_RANK_W-1:0] node_rank = RANK_AT_RESET;
  logic                  in_tree = 1'b0;
  reply_result_t         expected_replies[$];
  int                    fail_count = 0;
  int                    queued = 0;

  assign mismatches = fail_count;
  assign pending    = queued;

  function automatic void choose_parent();
    for (int i = 0; i < nbr_count; i++) begin
      if (!parent_ok) begin
        parent_idx = i;
        parent_ok  = 1'b1;
      end
      if (nbr_rank[i] < nbr_rank[parent_idx] ||
          (nbr_rank[i] == nbr_rank[parent_idx] && nbr_rssi[i] > nbr_rssi[parent_idx]))
        parent_idx = i;
    end
    if (parent_ok)
      node_rank = OWN_RANK_W'(nbr_rank[parent_idx]) + OWN_RANK_W'(1);
  endfunction

  function automatic reply_result_t predict_reply(input logic [IN_ADDR_W-1:0] addr,
                                                  input logic [RANK_W-1:0] rank,
                                                  input logic [RSSI_W-1:0] rssi);
    logic [KEY_W-1:0] key;
    int               slot;
    reply_result_t    res;
    key  = addr[KEY_W-1:0];
    slot = -1;
    for (int i = 0; i < nbr_count; i++)
      if (slot < 0 && nbr_addr[i] == key)
        slot = i;
    res.accepted = 1'b1;
    if (slot < 0) begin
      if (nbr_count >= TABLE_DEPTH) begin
        res.accepted = 1'b0;
      end else begin
        slot = nbr_count;
        nbr_addr[slot] = key;
        nbr_rank[slot] = rank;
        nbr_count++;
      end
    end
    if (res.accepted) begin
      nbr_rssi[slot] = rssi;
      in_tree = 1'b1;
      choose_parent();
    end
    res.joined      = in_tree;
    res.has_parent  = parent_ok;
    res.parent_addr = parent_ok ? IN_ADDR_W'(nbr_addr[parent_idx]) : '0;
    res.own_rank    = node_rank;
    return res;
  endfunction

  task automatic note_fault(input string what);
    fail_count++;
    if (fail_count <= 10)
      $display("%0t: %s", $time, what);
  endtask

  always @(posedge clk) begin
    reply_result_t want;
    if (!rst_n) begin
      nbr_count  = 0;
      parent_idx = 0;
      parent_ok  = 1'b0;
      node_rank  = RANK_AT_RESET;
      in_tree    = 1'b0;
      expected_replies.delete();
    end else begin
      if (out_valid === 1'b1) begin
        if (expected_replies.size() == 0) begin
          note_fault($sformatf("result without a pending transfer: acc=%0b addr=%h rank=%0d",
                               out_accepted, out_parent_addr, out_own_rank));
        end else begin
          want = expected_replies.pop_front();
          if (out_accepted !== want.accepted || out_joined !== want.joined ||
              out_has_parent !== want.has_parent || out_parent_addr !== want.parent_addr ||
              out_own_rank !== want.own_rank)
            note_fault($sformatf({"result mismatch: expected acc=%0b join=%0b par=%0b ",
                                  "addr=%h rank=%0d, got acc=%0b join=%0b par=%0b ",
                                  "addr=%h rank=%0d"},
                                 want.accepted, want.joined, want.has_parent,
                                 want.parent_addr, want.own_rank,
                                 out_accepted, out_joined, out_has_parent,
                                 out_parent_addr, out_own_rank));
        end
      end
      if (start && !busy)
        expected_replies.push_back(predict_reply(in_neighbor_addr, in_neighbor_rank,
                                                 in_link_rssi));
    end
    queued = expected_replies.size();
  end

endmodule

// ----- tb/tb.sv -----
// Testbench top: drives reply transfers into the tree parent selector and gives the verdict.
`timescale 1ns / 1ps
module tb;
  import tps_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int RANDOM_ITEMS = 430;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  start = 1'b0;
  logic [IN_ADDR_W-1:0]  in_neighbor_addr = '0;
  logic [RANK_W-1:0]     in_neighbor_rank = '0;
  logic [RSSI_W-1:0]     in_link_rssi = '0;
  logic                  busy;
  logic                  out_valid;
  logic                  out_accepted;
  logic                  out_joined;
  logic                  out_has_parent;
  logic [IN_ADDR_W-1:0]  out_parent_addr;
  logic [OWN_RANK_W-1:0] out_own_rank;
  int                    mismatches;
  int                    pending;
  int                    cycles = 0;
  logic [IN_ADDR_W-1:0]  known_addrs[$];

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  tree_parent_selector_unit DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_neighbor_addr(in_neighbor_addr),
    .in_neighbor_rank(in_neighbor_rank),
    .in_link_rssi    (in_link_rssi),
    .out_valid       (out_valid),
    .out_accepted    (out_accepted),
    .out_joined      (out_joined),
    .out_has_parent  (out_has_parent),
    .out_parent_addr (out_parent_addr),
    .out_own_rank    (out_own_rank)
  );

  tps_reply_checker reply_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_neighbor_addr(in_neighbor_addr),
    .in_neighbor_rank(in_neighbor_rank),
    .in_link_rssi    (in_link_rssi),
    .out_valid       (out_valid),
    .out_accepted    (out_accepted),
    .out_joined      (out_joined),
    .out_has_parent  (out_has_parent),
    .out_parent_addr (out_parent_addr),
    .out_own_rank    (out_own_rank),
    .mismatches      (mismatches),
    .pending         (pending)
  );

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic bit is_known(input logic [IN_ADDR_W-1:0] a);
    foreach (known_addrs[i])
      if (known_addrs[i] == a)
        return 1'b1;
    return 1'b0;
  endfunction

  function automatic logic [IN_ADDR_W-1:0] fresh_addr();
    logic [IN_ADDR_W-1:0] a;
    do
      a = IN_ADDR_W'($urandom);
    while (is_known(a));
    return a;
  endfunction

  task automatic send_reply(input logic [IN_ADDR_W-1:0] a, input logic [RANK_W-1:0] r,
                            input logic [RSSI_W-1:0] s, input int gap);
    repeat (gap) begin
      @(negedge clk);
      start            <= 1'b0;
      in_neighbor_addr <= IN_ADDR_W'($urandom);
      in_neighbor_rank <= RANK_W'($urandom);
      in_link_rssi     <= RSSI_W'($urandom);
    end
    @(negedge clk);
    start            <= 1'b1;
    in_neighbor_addr <= a;
    in_neighbor_rank <= r;
    in_link_rssi     <= s;
    do
      @(posedge clk);
    while (busy !== 1'b0);
    if (!is_known(a) && known_addrs.size() < TABLE_DEPTH)
      known_addrs.push_back(a);
  endtask

  initial begin
    int                   gap;
    int                   pick;
    logic [IN_ADDR_W-1:0] a;
    logic [RANK_W-1:0]    r;
    logic [RSSI_W-1:0]    s;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    send_reply(16'hFFFF, 8'd255, 16'h0000, 0);
    send_reply(16'h0000, 8'd255, 16'h0000, $urandom_range(0, 11));
    send_reply(16'h0000, 8'd7, 16'hFFFF, 0);
    send_reply(16'h1234, 8'd255, 16'hFFFF, 3);
    send_reply(16'h00FF, 8'd0, 16'h0000, 0);
    send_reply(16'hFF00, 8'd0, 16'h8000, 5);
    send_reply(16'hFF00, 8'd0, 16'h0000, 0);
    while (known_addrs.size() < TABLE_DEPTH)
      send_reply(fresh_addr(), RANK_W'($urandom_range(0, 2)), RSSI_W'($urandom_range(0, 3)),
                 $urandom_range(0, 11));
    send_reply(fresh_addr(), 8'd0, 16'hFFFF, 0);
    send_reply(16'h1234, 8'd0, 16'hFFFF, 2);

    // Hold the sender off until every transfer so far has produced its result.
    @(negedge clk);
    start <= 1'b0;
    while (pending != 0) @(negedge clk);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      gap  = ((n / 40) % 3 == 2) ? 0 : $urandom_range(0, 11);
      pick = $urandom_range(0, 99);
      if (pick < 70)
        a = known_addrs[$urandom_range(0, known_addrs.size() - 1)];
      else if (pick < 90)
        a = IN_ADDR_W'($urandom);
      else
        a = pick[0] ? '1 : '0;
      r    = RANK_W'($urandom);
      pick = $urandom_range(0, 99);
      if (pick < 50)
        s = RSSI_W'($urandom);
      else if (pick < 80)
        s = RSSI_W'($urandom_range(0, 3));
      else
        s = pick[0] ? '1 : '0;
      send_reply(a, r, s, gap);
    end

    @(negedge clk);
    start <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (40) @(posedge clk);
    if (mismatches == 0 && pending == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule
